// ----- hw/rtl/thermostat_heat_cool_controller_core_macros.svh -----
// ----------------------------------------------------------------------------
// thermostat_heat_cool_controller_core_macros: assertion helpers
// Implication checks, same cycle and next cycle, compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_HEAT_COOL_CONTROLLER_CORE_MACROS_SVH
`define THERMOSTAT_HEAT_COOL_CONTROLLER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define THC_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("thc: same-cycle check failed");

`define THC_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("thc: next-cycle check failed");

`else

`define THC_ASSERT_IMPLY(label, ck, rn, ante, cons)

`define THC_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

// ----- hw/rtl/thc_pkg.sv -----
// ----------------------------------------------------------------------------
// thc_pkg: shared types and constants of the thermostat controller
// Beat structs, configuration layout, status codes and reset values.
// ----------------------------------------------------------------------------
package thc_pkg;

    localparam int AVG_DEPTH_DEF = 10;

    localparam int ADC_W    = 10;
    localparam int TEMP_W   = 9;
    localparam int SP_W     = 8;
    localparam int MARGIN_W = 6;
    localparam int LIMIT_W  = 4;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int TEMP_MAX = 499;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_STEP     = 3'd4;

    localparam logic [MARGIN_W-1:0] MARGIN_RST  = 6'd5;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 4'd5;
    localparam logic [SP_W-1:0]     SP_MIN_RST  = 8'd35;
    localparam logic [SP_W-1:0]     SP_MAX_RST  = 8'd75;
    localparam logic [STEP_W-1:0]   SP_STEP_RST = 4'd5;
    localparam logic [SP_W-1:0]     DESIRED_RST = 8'd60;

    typedef enum logic [2:0] {
        ST_OFF       = 3'd0,
        ST_STABLE    = 3'd1,
        ST_HEATING   = 3'd2,
        ST_COOLING   = 3'd3,
        ST_HEAT_FAIL = 3'd4,
        ST_COOL_FAIL = 3'd5
    } status_t;

    typedef struct packed {
        logic [ADC_W-1:0] adc_sample;
        logic             power_press;
        logic             up_press;
        logic             down_press;
    } tick_beat_t;

    typedef struct packed {
        logic              heater_drive;
        logic              cooler_drive;
        logic              red_led;
        logic              blue_led;
        status_t           status;
        logic [TEMP_W-1:0] measured_temp;
        logic [SP_W-1:0]   setpoint;
        logic              setpoint_store;
    } result_beat_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_beat_t;

    typedef struct packed {
        logic [MARGIN_W-1:0] margin;
        logic [LIMIT_W-1:0]  stuck_limit;
        logic [SP_W-1:0]     sp_min;
        logic [SP_W-1:0]     sp_max;
        logic [STEP_W-1:0]   sp_step;
    } cfg_t;

    // per-tick control carried down the pipe
    typedef struct packed {
        logic            powered;
        logic            pwr_off;
        logic [SP_W-1:0] desired;
        logic            store;
    } ctl_t;

    typedef struct packed {
        ctl_t              ctl;
        logic [TEMP_W-1:0] sample;
    } s1_t;

endpackage

// ----- hw/rtl/thc_ram.sv -----
// ----------------------------------------------------------------------------
// thc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module thc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/thc_front.sv -----
// ----------------------------------------------------------------------------
// thc_front: accept stage
// Power toggle, setpoint stepping, sample scaling; holds the stage-1 beat.
// ----------------------------------------------------------------------------
module thc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  thc_pkg::cfg_t      cfg,
    input  thc_pkg::tick_beat_t tick,
    input  logic               accept,
    input  logic               s1_take,
    output logic               s1_valid,
    output thc_pkg::s1_t       s1,
    output logic               rd_en
);

    import thc_pkg::*;

    logic            powered_reg, powered_next;
    logic [SP_W-1:0] desired_reg, desired_next;
    logic            s1_valid_reg, s1_valid_next;
    s1_t             s1_reg;

    logic [SP_W:0]          nv_up;
    logic [SP_W-1:0]        d_up, nv_dn, d_dn;
    logic                   store;
    logic [ADC_W+TEMP_W-1:0] scaled;

    always_comb
    begin
        powered_next = powered_reg ^ tick.power_press;
        nv_up = {1'b0, desired_reg} + (SP_W+1)'(cfg.sp_step);
        d_up  = desired_reg;
        store = 1'b0;
        if (powered_next && tick.up_press && (desired_reg < cfg.sp_max))
        begin
            d_up  = (nv_up > {1'b0, cfg.sp_max}) ? cfg.sp_max : nv_up[SP_W-1:0];
            store = 1'b1;
        end
        nv_dn = (d_up >= SP_W'(cfg.sp_step)) ? (d_up - SP_W'(cfg.sp_step)) : '0;
        d_dn  = d_up;
        if (powered_next && tick.down_press && (d_up > cfg.sp_min))
        begin
            d_dn  = (nv_dn < cfg.sp_min) ? cfg.sp_min : nv_dn;
            store = 1'b1;
        end
        // adc * 500 / 1024
        scaled = (ADC_W+TEMP_W)'(tick.adc_sample) * (ADC_W+TEMP_W)'(500);

        desired_next  = accept ? d_dn : desired_reg;
        s1_valid_next = accept ? 1'b1 : (s1_take ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powered_reg  <= 1'b0;
            desired_reg  <= DESIRED_RST;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                powered_reg <= powered_next;
            end
            desired_reg  <= desired_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.ctl.powered <= powered_next;
            s1_reg.ctl.pwr_off <= tick.power_press & powered_reg;
            s1_reg.ctl.desired <= d_dn;
            s1_reg.ctl.store   <= store;
            s1_reg.sample      <= scaled[ADC_W+TEMP_W-1:ADC_W];
        end
    end

    assign rd_en    = accept & powered_next;
    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

// ----- hw/rtl/thc_accum.sv -----
// ----------------------------------------------------------------------------
// thc_accum: reading ring and running sum
// Ring in RAM, read at a powered accept, written back as the beat leaves stage 1;
// a same-entry write in the read cycle is forwarded. Holds the stage-2 beat.
// ----------------------------------------------------------------------------
module thc_accum #(
    parameter int AVG_DEPTH = thc_pkg::AVG_DEPTH_DEF,
    parameter int SUM_W     = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  thc_pkg::s1_t      s1,
    input  logic              s1_take,
    input  logic              s2_take,
    output logic              s2_valid,
    output thc_pkg::ctl_t     s2_ctl,
    output logic [SUM_W-1:0]  s2_sum
);

    import thc_pkg::*;

    localparam int AW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_POS = AW'(AVG_DEPTH - 1);

    logic [AW-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        wr_pos_reg;
    logic [AVG_DEPTH-1:0] written_reg, written_next;
    logic                 ent_valid_reg;
    logic                 fwd_reg;
    logic [TEMP_W-1:0]    fwd_data_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 s2_valid_reg, s2_valid_next;
    ctl_t                 s2_ctl_reg;

    logic              wr_en;
    logic              fwd_hit;
    logic [TEMP_W-1:0] rd_data;
    logic [TEMP_W-1:0] old_val;

    thc_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (AVG_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_pos_reg),
        .wr_data (s1.sample),
        .rd_en   (rd_en),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wr_en   = s1_take & s1.ctl.powered;
        fwd_hit = wr_en && (wr_pos_reg == pos_reg);
        pos_next = pos_reg;
        if (rd_en)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : (pos_reg + AW'(1));
        end
        written_next = written_reg;
        if (wr_en)
        begin
            written_next[wr_pos_reg] = 1'b1;
        end
        // entries never written read as zero
        old_val = ent_valid_reg ? (fwd_reg ? fwd_data_reg : rd_data) : '0;
        sum_next = sum_reg;
        if (wr_en)
        begin
            sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(s1.sample);
        end
        s2_valid_next = s1_take ? 1'b1 : (s2_take ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            written_reg   <= '0;
            sum_reg       <= '0;
            s2_valid_reg  <= 1'b0;
            ent_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            written_reg  <= written_next;
            sum_reg      <= sum_next;
            s2_valid_reg <= s2_valid_next;
            if (rd_en)
            begin
                ent_valid_reg <= written_reg[pos_reg] | fwd_hit;
                fwd_reg       <= fwd_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            wr_pos_reg   <= pos_reg;
            fwd_data_reg <= s1.sample;
        end
        if (s1_take)
        begin
            s2_ctl_reg <= s1.ctl;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_ctl   = s2_ctl_reg;
    assign s2_sum   = sum_reg;

endmodule

// ----- hw/rtl/thc_ctrl.sv -----
// ----------------------------------------------------------------------------
// thc_ctrl: averaging, stuck-sensor check, deadband control, result register
// Average by reciprocal multiply; held outputs kept across unpowered ticks, but a power-off tick sets them off.
// ----------------------------------------------------------------------------
module thc_ctrl #(
    parameter int AVG_DEPTH = thc_pkg::AVG_DEPTH_DEF,
    parameter int SUM_W     = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  thc_pkg::cfg_t         cfg,
    input  logic                  s2_valid,
    input  thc_pkg::ctl_t         s2_ctl,
    input  logic [SUM_W-1:0]      s2_sum,
    output logic                  s2_take,
    input  logic                  result_ready,
    output logic                  result_valid,
    output thc_pkg::result_beat_t result
);

    import thc_pkg::*;

    typedef struct packed {
        logic    heater;
        logic    cooler;
        logic    red;
        logic    blue;
        status_t status;
    } drv_t;

    localparam drv_t DRV_STABLE    = '{1'b0, 1'b0, 1'b0, 1'b0, ST_STABLE};
    localparam drv_t DRV_OFF       = '{1'b0, 1'b0, 1'b0, 1'b0, ST_OFF};
    localparam drv_t DRV_COOL      = '{1'b0, 1'b1, 1'b0, 1'b1, ST_COOLING};
    localparam drv_t DRV_COOL_FAIL = '{1'b0, 1'b0, 1'b0, 1'b0, ST_COOL_FAIL};
    localparam drv_t DRV_HEAT_FAIL = '{1'b0, 1'b0, 1'b0, 1'b0, ST_HEAT_FAIL};

    // exact floor(sum / AVG_DEPTH) for any SUM_W-bit sum
    localparam int SH = SUM_W + $clog2(AVG_DEPTH);
    localparam int PW = 2 * SUM_W + 1;
    localparam longint unsigned RECIP_VAL = ((64'd1 << SH) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [SUM_W:0] RECIP = RECIP_VAL[SUM_W:0];
    localparam logic [LIMIT_W-1:0] TICKS_SAT = '1;

    logic              heat_reg, heat_next;
    logic              cool_reg, cool_next;
    logic              fail_reg, fail_next;
    logic [LIMIT_W-1:0] ticks_reg, ticks_next;
    logic              blink_reg, blink_next;
    logic [TEMP_W-1:0] avg_now_reg, avg_now_next;
    logic [TEMP_W-1:0] avg_prev_reg, avg_prev_next;
    drv_t              drv_reg, drv_next;
    logic              out_valid_reg, out_valid_next;
    result_beat_t      result_reg;

    logic [PW-1:0]     prod;
    logic [TEMP_W-1:0] avg;
    logic [TEMP_W:0]   cool_thr;
    logic [TEMP_W:0]   avg_plus_m;

    always_comb
    begin
        prod       = PW'(s2_sum) * PW'(RECIP);
        avg        = prod[SH +: TEMP_W];
        cool_thr   = (TEMP_W+1)'(s2_ctl.desired) + (TEMP_W+1)'(cfg.margin);
        avg_plus_m = (TEMP_W+1)'(avg) + (TEMP_W+1)'(cfg.margin);

        s2_take        = s2_valid & (~out_valid_reg | result_ready);
        out_valid_next = s2_take ? 1'b1 : (result_ready ? 1'b0 : out_valid_reg);

        heat_next     = heat_reg;
        cool_next     = cool_reg;
        fail_next     = fail_reg;
        ticks_next    = ticks_reg;
        blink_next    = blink_reg;
        avg_now_next  = avg_now_reg;
        avg_prev_next = avg_prev_reg;
        drv_next      = drv_reg;

        if (!s2_ctl.powered)
        begin
            if (s2_ctl.pwr_off)
            begin
                drv_next = DRV_OFF;
            end
        end
        else
        begin
            avg_now_next = avg;
            if ((heat_reg || cool_reg) && (avg == avg_prev_reg))
            begin
                ticks_next = (ticks_reg == TICKS_SAT) ? ticks_reg : (ticks_reg + LIMIT_W'(1));
                if (ticks_next >= cfg.stuck_limit)
                begin
                    fail_next = 1'b1;
                end
            end
            else
            begin
                ticks_next = '0;
                fail_next  = 1'b0;
            end
            avg_prev_next = avg;

            priority if ((TEMP_W+1)'(avg) >= cool_thr)
            begin
                cool_next = 1'b1;
                heat_next = 1'b0;
                drv_next  = fail_next ? DRV_COOL_FAIL : DRV_COOL;
            end
            else if (avg_plus_m <= (TEMP_W+1)'(s2_ctl.desired))
            begin
                blink_next = ~blink_reg;
                heat_next  = 1'b1;
                cool_next  = 1'b0;
                drv_next   = fail_next ? DRV_HEAT_FAIL
                                       : drv_t'{1'b1, 1'b0, blink_reg, 1'b0, ST_HEATING};
            end
            else
            begin
                heat_next  = 1'b0;
                cool_next  = 1'b0;
                fail_next  = 1'b0;
                ticks_next = '0;
                drv_next   = DRV_STABLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_reg      <= 1'b0;
            cool_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            ticks_reg     <= '0;
            blink_reg     <= 1'b0;
            avg_now_reg   <= '0;
            avg_prev_reg  <= '0;
            drv_reg       <= DRV_STABLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s2_take)
            begin
                heat_reg     <= heat_next;
                cool_reg     <= cool_next;
                fail_reg     <= fail_next;
                ticks_reg    <= ticks_next;
                blink_reg    <= blink_next;
                avg_now_reg  <= avg_now_next;
                avg_prev_reg <= avg_prev_next;
                drv_reg      <= drv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            result_reg.heater_drive   <= drv_next.heater;
            result_reg.cooler_drive   <= drv_next.cooler;
            result_reg.red_led        <= drv_next.red;
            result_reg.blue_led       <= drv_next.blue;
            result_reg.status         <= drv_next.status;
            result_reg.measured_temp  <= avg_now_next;
            result_reg.setpoint       <= s2_ctl.desired;
            result_reg.setpoint_store <= s2_ctl.store;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// ----- hw/rtl/thermostat_heat_cool_controller_core.sv -----
// ----------------------------------------------------------------------------
// thermostat_heat_cool_controller_core: heat/cool thermostat with deadband
// Ticks pass the stage-1, stage-2 and result registers; one tick per cycle while result_ready does not stall.
// Ring RAM is read at a powered accept and written one stage later, same entry forwarded.
// Reset: power off, setpoint 60, ring reads zero via valid bits, no clear pass.
// ----------------------------------------------------------------------------
`include "thermostat_heat_cool_controller_core_macros.svh"

module thermostat_heat_cool_controller_core #(
    parameter int AVG_DEPTH = thc_pkg::AVG_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  thc_pkg::cfg_beat_t    cfg,
    input  logic                  tick_valid,
    output logic                  tick_ready,
    input  thc_pkg::tick_beat_t   tick,
    output logic                  result_valid,
    input  logic                  result_ready,
    output thc_pkg::result_beat_t result
);

    import thc_pkg::*;

    localparam int SUM_W = $clog2(TEMP_MAX * AVG_DEPTH + 1);

    cfg_t             cfg_reg;
    logic             accept;
    logic             rd_en;
    logic             s1_valid, s1_take;
    s1_t              s1;
    logic             s2_valid, s2_take;
    ctl_t             s2_ctl;
    logic [SUM_W-1:0] s2_sum;

    assign cfg_ready  = 1'b1;
    assign s1_take    = s1_valid & (~s2_valid | s2_take);
    assign tick_ready = ~s1_valid | s1_take;
    assign accept     = tick_valid & tick_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.margin      <= MARGIN_RST;
            cfg_reg.stuck_limit <= LIMIT_RST;
            cfg_reg.sp_min      <= SP_MIN_RST;
            cfg_reg.sp_max      <= SP_MAX_RST;
            cfg_reg.sp_step     <= SP_STEP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg.index)
                CFG_DEADBAND:    cfg_reg.margin      <= cfg.data[MARGIN_W-1:0];
                CFG_STUCK_LIMIT: cfg_reg.stuck_limit <= cfg.data[LIMIT_W-1:0];
                CFG_SP_MIN:      cfg_reg.sp_min      <= cfg.data[SP_W-1:0];
                CFG_SP_MAX:      cfg_reg.sp_max      <= cfg.data[SP_W-1:0];
                CFG_SP_STEP:     cfg_reg.sp_step     <= cfg.data[STEP_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    thc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .tick     (tick),
        .accept   (accept),
        .s1_take  (s1_take),
        .s1_valid (s1_valid),
        .s1       (s1),
        .rd_en    (rd_en)
    );

    thc_accum #(
        .AVG_DEPTH (AVG_DEPTH),
        .SUM_W     (SUM_W)
    ) u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .s1       (s1),
        .s1_take  (s1_take),
        .s2_take  (s2_take),
        .s2_valid (s2_valid),
        .s2_ctl   (s2_ctl),
        .s2_sum   (s2_sum)
    );

    thc_ctrl #(
        .AVG_DEPTH (AVG_DEPTH),
        .SUM_W     (SUM_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .s2_valid     (s2_valid),
        .s2_ctl       (s2_ctl),
        .s2_sum       (s2_sum),
        .s2_take      (s2_take),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

    `THC_ASSERT_IMPLY(a_one_drive, clk, rst_n, result_valid, !(result.heater_drive && result.cooler_drive))
    `THC_ASSERT_IMPLY(a_red_heats, clk, rst_n, result_valid && result.red_led, result.heater_drive)
    `THC_ASSERT_NEXT(a_accept_s1, clk, rst_n, accept, s1_valid)

endmodule

// ----- tb/thermostat_heat_cool_controller_core_tb.sv -----
// ----------------------------------------------------------------------------
// thermostat_heat_cool_controller_core_tb: tick-by-tick check of the thermostat
// Drives control ticks and register writes over valid/ready, predicts every
// result beat in a behavioral model of power, setpoint stepping, averaging,
// stuck-sensor detection and deadband control, and compares each result beat
// field by field under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module thermostat_heat_cool_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import thc_pkg::*;

    localparam int DRAIN_PAD = 8;
    localparam int RING_LEN  = AVG_DEPTH_DEF;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    cfg_beat_t    cfg = '0;
    logic         tick_valid = 1'b0;
    logic         tick_ready;
    tick_beat_t   tick = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    result_beat_t result;

    thermostat_heat_cool_controller_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg          (cfg),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .tick         (tick),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // register mirror
    int cfg_margin = int'(MARGIN_RST);
    int cfg_limit  = int'(LIMIT_RST);
    int cfg_min    = int'(SP_MIN_RST);
    int cfg_max    = int'(SP_MAX_RST);
    int cfg_step   = int'(SP_STEP_RST);

    // thermostat state mirror
    logic         pw_on = 1'b0;
    int           sp_now = int'(DESIRED_RST);
    int           ring [RING_LEN];
    int           ring_idx = 0;
    int           ring_sum = 0;
    int           avg_now = 0;
    int           avg_prev = 0;
    logic         heating = 1'b0;
    logic         cooling = 1'b0;
    logic         stuck = 1'b0;
    int           stuck_cnt = 0;
    logic         blink = 1'b0;
    result_beat_t held_out = '{status: ST_STABLE, default: '0};

    result_beat_t expected_results[$];
    int           mismatches = 0;
    int           ticks_sent = 0;
    int           results_seen = 0;
    int           ready_hold = 0;
    bit           no_idle = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("thermostat_heat_cool_controller_core: mismatch");
        $finish;
    end

    function automatic result_beat_t drive_word(input logic h, c, r, b, input status_t s);
        result_beat_t w;
        w = '0;
        w.heater_drive = h;
        w.cooler_drive = c;
        w.red_led      = r;
        w.blue_led     = b;
        w.status       = s;
        return w;
    endfunction

    function automatic void apply_cfg(input cfg_beat_t c);
        case (c.index)
            CFG_DEADBAND:    cfg_margin = int'(c.data[MARGIN_W-1:0]);
            CFG_STUCK_LIMIT: cfg_limit  = int'(c.data[LIMIT_W-1:0]);
            CFG_SP_MIN:      cfg_min    = int'(c.data);
            CFG_SP_MAX:      cfg_max    = int'(c.data);
            CFG_SP_STEP:     cfg_step   = int'(c.data[STEP_W-1:0]);
            default: ;
        endcase
    endfunction

    function automatic void predict_tick(input tick_beat_t t);
        result_beat_t r;
        int           smp;
        int           nv;
        logic         store;
        store = 1'b0;
        if (t.power_press)
        begin
            pw_on = !pw_on;
            if (!pw_on)
                held_out = drive_word(1'b0, 1'b0, 1'b0, 1'b0, ST_OFF);
        end
        if (pw_on)
        begin
            if (t.up_press && sp_now < cfg_max)
            begin
                nv = sp_now + cfg_step;
                sp_now = (nv > cfg_max) ? cfg_max : nv;
                store = 1'b1;
            end
            if (t.down_press && sp_now > cfg_min)
            begin
                nv = sp_now - cfg_step;
                sp_now = (nv < cfg_min) ? cfg_min : nv;
                store = 1'b1;
            end

            smp = (int'(t.adc_sample) * 500) / 1024;
            ring_sum = ring_sum - ring[ring_idx] + smp;
            ring[ring_idx] = smp;
            ring_idx = (ring_idx + 1) % RING_LEN;
            avg_now = ring_sum / RING_LEN;

            if ((heating || cooling) && avg_now == avg_prev)
            begin
                if (stuck_cnt < 15)
                    stuck_cnt++;
                if (stuck_cnt >= cfg_limit)
                    stuck = 1'b1;
            end
            else
            begin
                stuck_cnt = 0;
                stuck = 1'b0;
            end
            avg_prev = avg_now;

            if (avg_now >= sp_now + cfg_margin)
            begin
                cooling = 1'b1;
                heating = 1'b0;
                held_out = stuck ? drive_word(1'b0, 1'b0, 1'b0, 1'b0, ST_COOL_FAIL)
                                 : drive_word(1'b0, 1'b1, 1'b0, 1'b1, ST_COOLING);
            end
            else if (avg_now <= sp_now - cfg_margin)
            begin
                held_out = stuck ? drive_word(1'b0, 1'b0, 1'b0, 1'b0, ST_HEAT_FAIL)
                                 : drive_word(1'b1, 1'b0, blink, 1'b0, ST_HEATING);
                blink = !blink;
                heating = 1'b1;
                cooling = 1'b0;
            end
            else
            begin
                heating = 1'b0;
                cooling = 1'b0;
                stuck = 1'b0;
                stuck_cnt = 0;
                held_out = drive_word(1'b0, 1'b0, 1'b0, 1'b0, ST_STABLE);
            end
        end
        r = held_out;
        r.measured_temp  = avg_now[TEMP_W-1:0];
        r.setpoint       = sp_now[SP_W-1:0];
        r.setpoint_store = store;
        expected_results.push_back(r);
    endfunction

    function automatic string fmt_result(input result_beat_t r);
        return $sformatf("heat=%0b cool=%0b red=%0b blue=%0b status=%0d temp=%0d sp=%0d store=%0b",
                         r.heater_drive, r.cooler_drive, r.red_led, r.blue_led, r.status,
                         r.measured_temp, r.setpoint, r.setpoint_store);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // predict on accepted ticks and config beats, check accepted result beats
    always @(posedge clk)
    begin
        result_beat_t want;
        logic         bad;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_cfg(cfg);
            if (tick_valid && tick_ready)
                predict_tick(tick);
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %s", fmt_result(result));
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = (result.heater_drive   !== want.heater_drive)
                       || (result.cooler_drive   !== want.cooler_drive)
                       || (result.red_led        !== want.red_led)
                       || (result.blue_led       !== want.blue_led)
                       || (result.status         !== want.status)
                       || (result.measured_temp  !== want.measured_temp)
                       || (result.setpoint       !== want.setpoint)
                       || (result.setpoint_store !== want.setpoint_store);
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result beat %0d differs\n  exp %s\n  got %s",
                                     results_seen, fmt_result(want), fmt_result(result));
                    end
                end
            end
            if (ready_hold > 0)
            begin
                result_ready <= 1'b0;
                ready_hold--;
            end
            else if (!no_idle && $urandom_range(3) == 0)
            begin
                result_ready <= 1'b0;
                ready_hold = pick_gap();
            end
            else
                result_ready <= 1'b1;
        end
    end

    function automatic tick_beat_t make_tick(input logic [ADC_W-1:0] adc,
                                             input logic pwr, up, dn);
        tick_beat_t t;
        t.adc_sample  = adc;
        t.power_press = pwr;
        t.up_press    = up;
        t.down_press  = dn;
        return t;
    endfunction

    function automatic logic [ADC_W-1:0] adc_for_temp(input int temp);
        int a;
        a = (temp * 1024 + 499) / 500;
        if (a < 0)
            a = 0;
        if (a > 1023)
            a = 1023;
        return ADC_W'(a);
    endfunction

    // valid stays high across back-to-back beats; it drops only before a gap
    task automatic send_tick(input tick_beat_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick       <= t;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic drain_results();
        tick_valid <= 1'b0;
        while (results_seen < ticks_sent)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic set_config(input int margin, limit, lo, hi, stp);
        cfg_beat_t beats[5];
        int        k;
        beats[0] = '{index: CFG_DEADBAND,    data: CFG_DATA_W'(margin)};
        beats[1] = '{index: CFG_STUCK_LIMIT, data: CFG_DATA_W'(limit)};
        beats[2] = '{index: CFG_SP_MIN,      data: CFG_DATA_W'(lo)};
        beats[3] = '{index: CFG_SP_MAX,      data: CFG_DATA_W'(hi)};
        beats[4] = '{index: CFG_SP_STEP,     data: CFG_DATA_W'(stp)};
        for (k = 0; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg       <= beats[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // runs of steady or ramping readings near the setpoint, or of random readings and presses;
    // lean < 0 favors the down button, lean > 0 the up button
    task automatic run_traffic(input int n_items, input int lean);
        int         left;
        int         run_len;
        int         kind;
        int         temp;
        int         k;
        int         dir;
        logic       pwr;
        logic       up;
        logic       dn;
        tick_beat_t t;
        left = n_items;
        while (left > 0)
        begin
            kind    = $urandom_range(9);
            run_len = $urandom_range(40, 2);
            no_idle = ($urandom_range(4) == 0);
            temp    = sp_now + int'($urandom_range(2 * cfg_margin + 40)) - cfg_margin - 20;
            dir     = $urandom_range(1) ? 1 : -1;
            for (k = 0; k < run_len && left > 0; k++)
            begin
                if (kind >= 8)
                    t = make_tick(ADC_W'($urandom_range(1023)), $urandom_range(9) == 0,
                                  1'($urandom_range(1)), 1'($urandom_range(1)));
                else
                begin
                    if (kind >= 6)
                        temp += dir * int'($urandom_range(3));
                    pwr = pw_on ? ($urandom_range(99) == 0) : ($urandom_range(3) != 0);
                    up  = $urandom_range(lean > 0 ? 2 : 11) == 0;
                    dn  = $urandom_range(lean < 0 ? 2 : 11) == 0;
                    t = make_tick(adc_for_temp(temp), pwr, up, dn);
                end
                send_tick(t);
                left--;
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_unpowered_hold();
        send_tick(make_tick(10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(10'h3ff, 1'b0, 1'b1, 1'b1));
    endtask

    // heats from a cold reading while the buttons run the setpoint into its
    // upper limit and back down; the flat average trips the stuck check mid-way
    task automatic test_setpoint_buttons();
        int k;
        send_tick(make_tick(10'd0, 1'b1, 1'b0, 1'b0));
        for (k = 0; k < 4; k++)
            send_tick(make_tick(10'd0, 1'b0, 1'b1, 1'b0));
        send_tick(make_tick(10'd0, 1'b0, 1'b1, 1'b1));
        for (k = 0; k < 3; k++)
            send_tick(make_tick(10'd0, 1'b0, 1'b0, 1'b1));
    endtask

    task automatic test_deadband_and_power_off();
        int k;
        for (k = 0; k < 8; k++)
            send_tick(make_tick(10'h3ff, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(10'd512, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(10'd512, 1'b0, 1'b1, 1'b0));
        drain_results();
    endtask

    task automatic test_reset_config_traffic();
        run_traffic(150, 0);
        drain_results();
    endtask

    task automatic test_setting_sweep();
        int lo;
        int hi;
        set_config(0, 1, 0, 255, 1);
        run_traffic(150, 1);
        drain_results();
        set_config(63, 15, 0, 255, 15);
        run_traffic(150, -1);
        drain_results();
        set_config(3, 2, 100, 130, 7);
        run_traffic(150, 0);
        drain_results();
        set_config(10, 8, 200, 50, 15);
        run_traffic(100, 0);
        drain_results();
        lo = $urandom_range(120);
        hi = $urandom_range(255, lo);
        set_config($urandom_range(63), $urandom_range(15, 1), lo, hi, $urandom_range(15, 1));
        run_traffic(200, 0);
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unpowered_hold();
        test_setpoint_buttons();
        test_deadband_and_power_off();
        test_reset_config_traffic();
        test_setting_sweep();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("thermostat_heat_cool_controller_core: match");
        else
            $display("thermostat_heat_cool_controller_core: mismatch");
        $finish;
    end

endmodule
